[sv/dsw_pkg.sv]
`default_nettype none

package dsw_pkg;

    // display geometry and number format
    localparam int DIGITS   = 8;
    localparam int VALUE_W  = 32;
    localparam int CELLS    = 10;   // decimal digits a 32-bit value can need
    localparam int BCD_W    = 4;
    localparam int ADDR_W   = 4;
    localparam int SEG_W    = 8;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SEG_W-1:0] SEG_DOT   = 8'h80;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_WRITE
    } t_state;

    // control shared by every cell of the digit chain
    typedef struct packed {
        logic clear;
        logic shift;
        logic drain;
    } t_cell_ctl;

    function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h7E;
            4'd1:    seg = 8'h30;
            4'd2:    seg = 8'h6D;
            4'd3:    seg = 8'h79;
            4'd4:    seg = 8'h33;
            4'd5:    seg = 8'h5B;
            4'd6:    seg = 8'h5F;
            4'd7:    seg = 8'h70;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h7B;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

[sv/decimal_seven_segment_writer.sv]
// decimal seven-segment writer
// input channel (s_axis): one transaction carries a 32-bit unsigned number in
// tdata and the dot-mode flag in tuser
// output channel (m_axis): each number produces exactly eight register writes,
// addresses 8 down to 1, tdata = {segment byte, address}, tlast on address 1
// address 8 holds the least significant digit; positions above the highest
// nonzero digit are blank (0x00), zero shows a single '0', and only the low
// eight decimal digits are kept
// the number is converted by a row of ten bcd digit cells, one value bit
// shifted in per cycle, then the cells shift down one digit per
// write so the lowest cell always holds the digit being written
// sequence: accept, convert every value bit, then the first write is registered
// the input is ready only while no conversion or write sequence is running;
// the final write may still sit in the output register while the next number
// is accepted
// a stall on m_axis freezes the write sequence; nothing is dropped
// reset (synchronous, active low) empties the output register and returns to idle
// the input is not ready while reset is held
`default_nettype none

module decimal_seven_segment_writer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [dsw_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [31:0] value
    input  wire logic                                 s_axis_tuser,  // [0] func
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [dsw_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,  // [3:0] reg_addr,
                                                                     // [11:4] seg_byte
    output logic                                      m_axis_tlast   // last_write
);

    localparam int CELLS = dsw_pkg::CELLS;
    localparam int BCD_W = dsw_pkg::BCD_W;

    dsw_pkg::t_state r_state, n_state;

    logic [dsw_pkg::VALUE_W-1:0]  r_bin, n_bin;       // bits still to shift in
    logic [dsw_pkg::BITCNT_W-1:0] r_bitcnt, n_bitcnt;
    logic                         r_dot, n_dot;
    logic [dsw_pkg::ADDR_W-1:0]   r_pos, n_pos;       // address of next write
    logic                         r_first, n_first;   // next write is the lowest digit

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [dsw_pkg::ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [dsw_pkg::SEG_W-1:0]    r_out_seg, n_out_seg;
    logic                         r_out_last, n_out_last;

    dsw_pkg::t_cell_ctl           cell_ctl;
    logic [CELLS:0]               chain_bit;
    logic [BCD_W-1:0]             chain_digit [CELLS+1];
    logic [CELLS*BCD_W-1:0]       all_digits;

    logic in_accept;
    logic out_free;
    logic show;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    // digit chain: bits ripple upward while converting, digits move down while writing
    assign chain_bit[0]       = r_bin[dsw_pkg::VALUE_W-1];
    assign chain_digit[CELLS] = '0;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        dsw_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_bit   (chain_bit[g]),
            .i_upper (chain_digit[g+1]),
            .o_bit   (chain_bit[g+1]),
            .o_digit (chain_digit[g])
        );
        assign all_digits[g*BCD_W +: BCD_W] = chain_digit[g];
    end

    // a position is shown when it is the lowest one or any digit at or above it is nonzero
    assign show = r_first || (|all_digits);

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bitcnt    = r_bitcnt;
        n_dot       = r_dot;
        n_pos       = r_pos;
        n_first     = r_first;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_seg   = r_out_seg;
        n_out_last  = r_out_last;
        cell_ctl    = '0;
        s_axis_tready = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            dsw_pkg::ST_IDLE: begin
                s_axis_tready = i_rst_n;
                if (in_accept) begin
                    n_bin          = s_axis_tdata;
                    n_dot          = s_axis_tuser;
                    n_bitcnt       = '0;
                    cell_ctl.clear = 1'b1;
                    n_state        = dsw_pkg::ST_CONVERT;
                end
            end
            dsw_pkg::ST_CONVERT: begin
                cell_ctl.shift = 1'b1;
                n_bin          = {r_bin[dsw_pkg::VALUE_W-2:0], 1'b0};
                n_bitcnt       = r_bitcnt + 1'b1;
                if (r_bitcnt == dsw_pkg::BITCNT_W'(dsw_pkg::VALUE_W - 1)) begin
                    n_pos   = dsw_pkg::ADDR_W'(dsw_pkg::DIGITS);
                    n_first = 1'b1;
                    n_state = dsw_pkg::ST_WRITE;
                end
            end
            dsw_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_addr     = r_pos;
                    n_out_seg      = show ? (dsw_pkg::seg_of(chain_digit[0])
                                             | (r_dot ? dsw_pkg::SEG_DOT : dsw_pkg::SEG_BLANK))
                                          : dsw_pkg::SEG_BLANK;
                    n_out_last     = (r_pos == dsw_pkg::ADDR_W'(1));
                    cell_ctl.drain = 1'b1;
                    n_first        = 1'b0;
                    n_pos          = r_pos - 1'b1;
                    if (r_pos == dsw_pkg::ADDR_W'(1)) begin
                        n_state = dsw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = dsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsw_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bitcnt   <= n_bitcnt;
        r_dot      <= n_dot;
        r_pos      <= n_pos;
        r_first    <= n_first;
        r_out_addr <= n_out_addr;
        r_out_seg  <= n_out_seg;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(dsw_pkg::OUT_TDATA_W - dsw_pkg::SEG_W - dsw_pkg::ADDR_W){1'b0}},
                            r_out_seg, r_out_addr};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // an accepted number always starts a conversion
    a_accept_converts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == dsw_pkg::ST_CONVERT)
        else $error("accepted number did not start conversion");

    // the final write of a number is always address 1
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'd1)
        else $error("last write not at address 1");

    // the digit being written is always a valid decimal digit
    a_bcd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dsw_pkg::ST_WRITE |-> chain_digit[0] <= 4'd9)
        else $error("digit chain holds a non-decimal digit");
`endif

endmodule

`default_nettype wire

[sv/dsw_cell.sv]
`default_nettype none

// one decimal digit of the shift-and-add-3 chain
module dsw_cell (
    input  wire logic                       i_clk,
    input  wire dsw_pkg::t_cell_ctl         i_ctl,
    input  wire logic                       i_bit,
    input  wire logic [dsw_pkg::BCD_W-1:0]  i_upper,
    output logic                            o_bit,
    output logic [dsw_pkg::BCD_W-1:0]       o_digit
);

    logic [dsw_pkg::BCD_W-1:0] r_digit;
    logic [dsw_pkg::BCD_W-1:0] n_digit;
    logic [dsw_pkg::BCD_W-1:0] adj;

    always_comb begin
        adj = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        priority if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift) begin
            n_digit = {adj[dsw_pkg::BCD_W-2:0], i_bit};
        end else if (i_ctl.drain) begin
            n_digit = i_upper;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_bit   = adj[dsw_pkg::BCD_W-1];
    assign o_digit = r_digit;

endmodule

`default_nettype wire

[bench/tb_decimal_seven_segment_writer.sv]
module tb_decimal_seven_segment_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_ITEMS  = 137;
    localparam int MAX_GAP       = 18;
    localparam int LONG_HOLD     = 400;   // cycles the receiver refuses writes once
    localparam int TAIL_CYCLES   = 60;    // a bit more than one item's latency

    // digit to segment pattern, dot bit clear
    localparam logic [dsw_pkg::SEG_W-1:0] SEG_PATTERN [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    // one register write as seen on the output channel
    typedef struct packed {
        logic [dsw_pkg::ADDR_W-1:0] addr;
        logic [dsw_pkg::SEG_W-1:0]  seg;
        logic                       last;
    } t_digit_write;

    // directed row: when hand_typed is set, segs holds the eight segment bytes,
    // the one for address 8 in the lowest byte
    typedef struct packed {
        logic                           hand_typed;
        logic                           dot;
        logic [dsw_pkg::VALUE_W-1:0]    value;
        logic [dsw_pkg::DIGITS*8-1:0]   segs;
    } t_display_row;

    localparam t_display_row DIRECTED [DIRECTED_ROWS] = '{
        // zero shows one '0' at the lowest position, blanks stay blank in dot mode
        '{1'b1, 1'b0, 32'd0,          64'h0000_0000_0000_007E},
        '{1'b1, 1'b1, 32'd0,          64'h0000_0000_0000_00FE},
        // nine digits: the leading one is dropped, eight zeros remain
        '{1'b1, 1'b0, 32'd100000000,  64'h7E7E_7E7E_7E7E_7E7E},
        '{1'b1, 1'b0, 32'd99999999,   64'h7B7B_7B7B_7B7B_7B7B},
        '{1'b1, 1'b0, 32'd88888888,   64'h7F7F_7F7F_7F7F_7F7F},
        '{1'b1, 1'b1, 32'd88888888,   64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b0, 1'b0, 32'd1,          64'h0},
        '{1'b0, 1'b1, 32'd9,          64'h0},
        '{1'b0, 1'b0, 32'd10,         64'h0},
        '{1'b0, 1'b1, 32'd7,          64'h0},
        '{1'b0, 1'b1, 32'd1234,       64'h0},
        '{1'b0, 1'b0, 32'd1000,       64'h0},
        '{1'b0, 1'b0, 32'd12345678,   64'h0},
        '{1'b0, 1'b1, 32'd87654321,   64'h0},
        '{1'b0, 1'b1, 32'd90807060,   64'h0},
        '{1'b0, 1'b0, 32'd9999999,    64'h0},
        '{1'b0, 1'b1, 32'd10000000,   64'h0},
        '{1'b0, 1'b1, 32'd1000000000, 64'h0},
        '{1'b0, 1'b0, 32'hFFFF_FFFF,  64'h0},
        '{1'b0, 1'b1, 32'hFFFF_FFFF,  64'h0},
        '{1'b0, 1'b0, 32'h8000_0000,  64'h0},
        '{1'b0, 1'b1, 32'hAAAA_AAAA,  64'h0},
        '{1'b0, 1'b0, 32'h5555_5555,  64'h0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [dsw_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] value
    logic                            s_axis_tuser = 1'b0; // [0] func
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [dsw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // [3:0] reg_addr, [11:4] seg_byte
    logic                            m_axis_tlast;        // last_write

    // register writes still owed by the block, oldest first
    t_digit_write pending_writes [$];
    int           mismatch_count = 0;
    int unsigned  writes_seen = 0;
    bit           hold_output = 1'b0;   // sender asks the receiver for one long stall

    decimal_seven_segment_writer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle cycles before the next transaction; zero throughout a burst
    function automatic int unsigned draw_gap(input bit burst);
        if (burst) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // the eight writes one number turns into: address 8 gets the lowest digit,
    // digits stop after the highest nonzero one and the rest are blank
    function automatic void predict_display_writes(input logic dot,
                                                   input logic [dsw_pkg::VALUE_W-1:0] value);
        logic [dsw_pkg::VALUE_W-1:0] rest;
        logic                        showing;
        t_digit_write                w;
        rest    = value;
        showing = 1'b1;
        for (int pos = dsw_pkg::DIGITS; pos >= 1; pos--) begin
            w.addr = dsw_pkg::ADDR_W'(pos);
            w.last = (pos == 1);
            if (showing) begin
                w.seg   = SEG_PATTERN[rest % 10]
                          | (dot ? dsw_pkg::SEG_DOT : dsw_pkg::SEG_BLANK);
                rest    = rest / 10;
                showing = (rest != 0);
            end else begin
                w.seg = dsw_pkg::SEG_BLANK;
            end
            pending_writes.push_back(w);
        end
    endfunction

    // offer one number, hold it until accepted, then queue what it must produce
    task automatic send_number(input t_display_row row, input int unsigned gap);
        t_digit_write w;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.value;
        s_axis_tuser  <= row.dot;
        do @(posedge i_clk); while (!s_axis_tready);
        if (row.hand_typed) begin
            for (int k = 0; k < dsw_pkg::DIGITS; k++) begin
                w.addr = dsw_pkg::ADDR_W'(dsw_pkg::DIGITS - k);
                w.seg  = row.segs[k*8 +: 8];
                w.last = (k == dsw_pkg::DIGITS - 1);
                pending_writes.push_back(w);
            end
        end else begin
            predict_display_writes(row.dot, row.value);
        end
    endtask

    // random number: half the time a chosen count of decimal digits, so blanking
    // lands on every position above the lowest, plus full-range and over-eight-digit values
    function automatic logic [dsw_pkg::VALUE_W-1:0] draw_value();
        longint unsigned lim;
        int unsigned     digits;
        unique case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(100000000, 32'hFFFF_FFFF);
            default: begin
                digits = $urandom_range(1, dsw_pkg::DIGITS);
                lim    = 1;
                repeat (digits) lim = lim * 10;
                return $urandom_range(0, 32'(lim - 1));
            end
        endcase
    endfunction

    // stimulus
    initial begin
        t_display_row row;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_number(DIRECTED[i], draw_gap((i / 8) % 2 == 1));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // early on, stall the output for a long stretch while numbers keep coming
            if (i == 4) begin
                hold_output = 1'b1;
            end
            // halfway, stop offering until the block has drained completely
            if (i == RANDOM_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (pending_writes.size() != 0) @(posedge i_clk);
            end
            row.hand_typed = 1'b0;
            row.dot        = $urandom_range(0, 1);
            row.value      = draw_value();
            row.segs       = '0;
            send_number(row, draw_gap((i / 16) % 3 == 0));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_writes.size() != 0) begin
            $display("%0t: %0d register writes never arrived", $time, pending_writes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver: random stalls per write, bursts with none, one long hold-off
    initial begin
        int unsigned gap;
        @(posedge i_clk iff i_rst_n);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                hold_output = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                gap = draw_gap((writes_seen / 40) % 3 == 1);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // checker: every accepted write against the oldest owed one
    always @(posedge i_clk) begin
        t_digit_write want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            writes_seen <= writes_seen + 1;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write, expected none, actual %0d/%02h/%0b",
                         $time, m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_writes.pop_front();
                if (m_axis_tdata[3:0] !== want.addr || m_axis_tdata[11:4] !== want.seg
                        || m_axis_tlast !== want.last) begin
                    $display("%0t: write mismatch, expected %0d/%02h/%0b, actual %0d/%02h/%0b",
                             $time, want.addr, want.seg, want.last,
                             m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
